// ===== rtl/ial_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ial_pkg
// Shared types, codes and helpers for the indexed array list unit.
// ----------------------------------------------------------------------------
package ial_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int KEY_WIDTH_DEF  = 16;
    localparam int CMD_W          = 3;
    localparam int STATUS_W       = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 3'd0,
        CMD_INSERT  = 3'd1,
        CMD_DELETE  = 3'd2,
        CMD_READ    = 3'd3,
        CMD_SEARCH  = 3'd4,
        CMD_REVERSE = 3'd5,
        CMD_CLEAR   = 3'd6,
        CMD_LENGTH  = 3'd7
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_MOVE_HEAD
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REVERSE
    } t_state;

    function automatic int bytes_up(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ial_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ial_cell
// One list slot: holds one element and takes it from a neighbor, the head
// or the broadcast value, as the shared cell operation selects.
// ----------------------------------------------------------------------------
module ial_cell #(
    parameter int ELEM_WIDTH = ial_pkg::ELEM_WIDTH_DEF,
    parameter int IDX_W      = $clog2(ial_pkg::CAPACITY_DEF)
) (
    input  wire logic                  i_clk,
    input  wire logic [IDX_W-1:0]      i_index,
    input  wire ial_pkg::t_cell_op     i_op,
    input  wire logic [IDX_W-1:0]      i_sel,
    input  wire logic [ELEM_WIDTH-1:0] i_value,
    input  wire logic [ELEM_WIDTH-1:0] i_left,
    input  wire logic [ELEM_WIDTH-1:0] i_right,
    input  wire logic [ELEM_WIDTH-1:0] i_head,
    output logic      [ELEM_WIDTH-1:0] o_elem
);

    logic [ELEM_WIDTH-1:0] r_elem;
    logic [ELEM_WIDTH-1:0] n_elem;

    always_comb begin
        n_elem = r_elem;
        case (i_op)
            ial_pkg::CELL_LOAD: begin
                if (i_index == i_sel) begin
                    n_elem = i_value;
                end
            end
            ial_pkg::CELL_INSERT: begin
                if (i_index > i_sel) begin
                    n_elem = i_left;
                end else if (i_index == i_sel) begin
                    n_elem = i_value;
                end
            end
            ial_pkg::CELL_DELETE: begin
                if (i_index >= i_sel) begin
                    n_elem = i_right;
                end
            end
            ial_pkg::CELL_MOVE_HEAD: begin
                if (i_index < i_sel) begin
                    n_elem = i_right;
                end else if (i_index == i_sel) begin
                    n_elem = i_head;
                end
            end
            default: begin
                n_elem = r_elem;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_elem <= n_elem;
    end

    assign o_elem = r_elem;

endmodule
`default_nettype wire

// ===== rtl/ial_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ial_ctrl
// Command sequencer: checks each command against the count, drives the cell
// row, scans the head during read and search, and holds the result beat.
// ----------------------------------------------------------------------------
module ial_ctrl #(
    parameter int CAPACITY   = ial_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = ial_pkg::ELEM_WIDTH_DEF,
    parameter int KEY_WIDTH  = ial_pkg::KEY_WIDTH_DEF,
    parameter int IDX_W      = $clog2(CAPACITY),
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire ial_pkg::t_cmd         i_command,
    input  wire logic [CNT_W-1:0]      i_position,
    input  wire logic [ELEM_WIDTH-1:0] i_elem_value,
    input  wire logic [KEY_WIDTH-1:0]  i_search_key,
    input  wire logic [ELEM_WIDTH-1:0] i_head,
    output ial_pkg::t_cell_op          o_cell_op,
    output logic      [IDX_W-1:0]      o_cell_sel,
    output logic      [ELEM_WIDTH-1:0] o_cell_value,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output ial_pkg::t_status           o_status,
    output logic      [ELEM_WIDTH-1:0] o_elem_out,
    output logic      [CNT_W-1:0]      o_found_position,
    output logic      [CNT_W-1:0]      o_list_length
);

    localparam int KEY_LO = (ELEM_WIDTH > KEY_WIDTH) ? (ELEM_WIDTH - KEY_WIDTH) : 0;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    ial_pkg::t_state  r_state, n_state;
    ial_pkg::t_cmd    r_cmd, n_cmd;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_tgt, n_tgt;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [IDX_W-1:0] r_step, n_step;
    logic             r_hit, n_hit;
    logic [ELEM_WIDTH-1:0] r_cap, n_cap;
    logic [CNT_W-1:0] r_fpos, n_fpos;

    logic             r_out_valid, n_out_valid;
    ial_pkg::t_status r_out_status, n_out_status;
    logic [ELEM_WIDTH-1:0] r_out_elem, n_out_elem;
    logic [CNT_W-1:0] r_out_fpos, n_out_fpos;
    logic [CNT_W-1:0] r_out_len, n_out_len;

    logic             accept;
    logic             load_out;
    ial_pkg::t_status res_status;
    logic [ELEM_WIDTH-1:0] res_elem;
    logic [CNT_W-1:0] res_fpos;
    logic [IDX_W-1:0] last_idx;
    logic [ELEM_WIDTH+KEY_WIDTH-1:0] head_ext;
    logic [KEY_WIDTH-1:0] head_key;
    logic             take_now;
    logic [CNT_W:0]   pos_ext;
    logic [CNT_W:0]   cnt_ext;

    assign head_ext = {{KEY_WIDTH{1'b0}}, i_head} >> KEY_LO;
    assign head_key = head_ext[KEY_WIDTH-1:0];
    assign last_idx = IDX_W'(r_count - CNT_W'(1));
    assign pos_ext  = {1'b0, i_position};
    assign cnt_ext  = {1'b0, r_count};

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_count      = r_count;
        n_tgt        = r_tgt;
        n_key        = r_key;
        n_step       = r_step;
        n_hit        = r_hit;
        n_cap        = r_cap;
        n_fpos       = r_fpos;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_elem   = r_out_elem;
        n_out_fpos   = r_out_fpos;
        n_out_len    = r_out_len;
        o_cell_op    = ial_pkg::CELL_HOLD;
        o_cell_sel   = '0;
        o_cell_value = i_elem_value;
        load_out     = 1'b0;
        res_status   = ial_pkg::ST_OK;
        res_elem     = '0;
        res_fpos     = '0;
        take_now     = 1'b0;

        o_ready = (r_state == ial_pkg::S_IDLE) && (!r_out_valid || i_ready);
        accept  = i_valid && o_ready;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ial_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd  = i_command;
                    n_key  = i_search_key;
                    n_tgt  = IDX_W'(i_position - CNT_W'(1));
                    n_step = '0;
                    n_hit  = 1'b0;
                    n_cap  = '0;
                    n_fpos = '0;
                    case (i_command)
                        ial_pkg::CMD_APPEND: begin
                            load_out = 1'b1;
                            if (r_count == CAP_CNT) begin
                                res_status = ial_pkg::ST_FULL;
                            end else begin
                                o_cell_op  = ial_pkg::CELL_LOAD;
                                o_cell_sel = IDX_W'(r_count);
                                n_count    = r_count + CNT_W'(1);
                            end
                        end
                        ial_pkg::CMD_INSERT: begin
                            load_out = 1'b1;
                            if (r_count == CAP_CNT) begin
                                res_status = ial_pkg::ST_FULL;
                            end else if (i_position == '0 ||
                                         pos_ext > cnt_ext + (CNT_W+1)'(1)) begin
                                res_status = ial_pkg::ST_BADPOS;
                            end else begin
                                o_cell_op  = ial_pkg::CELL_INSERT;
                                o_cell_sel = IDX_W'(i_position - CNT_W'(1));
                                n_count    = r_count + CNT_W'(1);
                            end
                        end
                        ial_pkg::CMD_DELETE: begin
                            load_out = 1'b1;
                            if (r_count == '0) begin
                                res_status = ial_pkg::ST_EMPTY;
                            end else if (i_position == '0 || i_position > r_count) begin
                                res_status = ial_pkg::ST_BADPOS;
                            end else begin
                                o_cell_op  = ial_pkg::CELL_DELETE;
                                o_cell_sel = IDX_W'(i_position - CNT_W'(1));
                                n_count    = r_count - CNT_W'(1);
                            end
                        end
                        ial_pkg::CMD_READ: begin
                            if (r_count == '0) begin
                                load_out   = 1'b1;
                                res_status = ial_pkg::ST_EMPTY;
                            end else if (i_position == '0 || i_position > r_count) begin
                                load_out   = 1'b1;
                                res_status = ial_pkg::ST_BADPOS;
                            end else begin
                                n_state = ial_pkg::S_SCAN;
                            end
                        end
                        ial_pkg::CMD_SEARCH: begin
                            if (r_count == '0) begin
                                load_out   = 1'b1;
                                res_status = ial_pkg::ST_EMPTY;
                            end else begin
                                n_state = ial_pkg::S_SCAN;
                            end
                        end
                        ial_pkg::CMD_REVERSE: begin
                            if (r_count == '0) begin
                                load_out   = 1'b1;
                                res_status = ial_pkg::ST_EMPTY;
                            end else if (r_count == CNT_W'(1)) begin
                                load_out = 1'b1;
                            end else begin
                                n_step  = last_idx;
                                n_state = ial_pkg::S_REVERSE;
                            end
                        end
                        ial_pkg::CMD_CLEAR: begin
                            load_out = 1'b1;
                            n_count  = '0;
                        end
                        ial_pkg::CMD_LENGTH: begin
                            load_out = 1'b1;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ial_pkg::S_SCAN: begin
                o_cell_op  = ial_pkg::CELL_MOVE_HEAD;
                o_cell_sel = last_idx;
                if (r_cmd == ial_pkg::CMD_READ) begin
                    take_now = (r_step == r_tgt);
                end else begin
                    take_now = !r_hit && (head_key == r_key);
                end
                if (take_now) begin
                    n_hit  = 1'b1;
                    n_cap  = i_head;
                    n_fpos = CNT_W'(r_step) + CNT_W'(1);
                end
                if (r_step == last_idx) begin
                    load_out = 1'b1;
                    n_state  = ial_pkg::S_IDLE;
                    res_elem = take_now ? i_head : r_cap;
                    if (r_cmd == ial_pkg::CMD_SEARCH) begin
                        if (take_now || r_hit) begin
                            res_fpos = take_now ? CNT_W'(r_step) + CNT_W'(1) : r_fpos;
                        end else begin
                            res_status = ial_pkg::ST_NOTFOUND;
                        end
                    end
                end else begin
                    n_step = r_step + IDX_W'(1);
                end
            end
            ial_pkg::S_REVERSE: begin
                o_cell_op  = ial_pkg::CELL_MOVE_HEAD;
                o_cell_sel = r_step;
                if (r_step == IDX_W'(1)) begin
                    load_out = 1'b1;
                    n_state  = ial_pkg::S_IDLE;
                end else begin
                    n_step = r_step - IDX_W'(1);
                end
            end
            default: begin
                n_state = ial_pkg::S_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid  = 1'b1;
            n_out_status = res_status;
            n_out_elem   = res_elem;
            n_out_fpos   = res_fpos;
            n_out_len    = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ial_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_tgt        <= n_tgt;
        r_key        <= n_key;
        r_step       <= n_step;
        r_hit        <= n_hit;
        r_cap        <= n_cap;
        r_fpos       <= n_fpos;
        r_out_status <= n_out_status;
        r_out_elem   <= n_out_elem;
        r_out_fpos   <= n_out_fpos;
        r_out_len    <= n_out_len;
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_elem_out       = r_out_elem;
    assign o_found_position = r_out_fpos;
    assign o_list_length    = r_out_len;

endmodule
`default_nettype wire

// ===== rtl/indexed_array_list_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_array_list_unit
// Bounded ordered list held in a row of cells, with append, insert, delete,
// read, key search, reverse, clear and length commands.
//
//   port group  dir  beat content (tdata, lowest bits first)
//   s_axis      in   command, position, elem_value, search_key
//   m_axis      out  status, elem_out, found_position, list_length
//
// Steps from input beat to result beat:
// Append, insert, delete, clear, length and every rejected command: the accept
// alone. Read and search: the accept plus one full rotation of the stored
// cells past the head cell. Reverse: the accept plus list_length - 1 head
// moves.
// Reset clears the count, the state and the result valid flag; cell contents stay as is.
// A new beat is taken only when no command is in progress and the result
// register is empty or being drained.
// ----------------------------------------------------------------------------
module indexed_array_list_unit #(
    parameter int CAPACITY   = ial_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = ial_pkg::ELEM_WIDTH_DEF,
    parameter int KEY_WIDTH  = ial_pkg::KEY_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // command, position, elem_value, search_key, zero fill
    input  wire logic [ial_pkg::bytes_up(ial_pkg::CMD_W + $clog2(CAPACITY + 1)
                       + ELEM_WIDTH + KEY_WIDTH)-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // status, elem_out, found_position, list_length, zero fill
    output logic      [ial_pkg::bytes_up(ial_pkg::STATUS_W + ELEM_WIDTH
                       + 2 * $clog2(CAPACITY + 1))-1:0] m_axis_tdata
);

    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IN_POS   = ial_pkg::CMD_W;
    localparam int IN_VAL   = IN_POS + CNT_W;
    localparam int IN_KEY   = IN_VAL + ELEM_WIDTH;
    localparam int OUT_BITS = ial_pkg::STATUS_W + ELEM_WIDTH + 2 * CNT_W;
    localparam int OUT_W    = ial_pkg::bytes_up(OUT_BITS);

    ial_pkg::t_cell_op     cell_op;
    logic [IDX_W-1:0]      cell_sel;
    logic [ELEM_WIDTH-1:0] cell_value;
    logic [ELEM_WIDTH-1:0] cell_elem [CAPACITY];

    ial_pkg::t_status      out_status;
    logic [ELEM_WIDTH-1:0] out_elem;
    logic [CNT_W-1:0]      out_fpos;
    logic [CNT_W-1:0]      out_len;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [ELEM_WIDTH-1:0] left_elem;
            logic [ELEM_WIDTH-1:0] right_elem;
            if (gi == 0) begin : g_first
                assign left_elem = '0;
            end else begin : g_mid_l
                assign left_elem = cell_elem[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_elem = '0;
            end else begin : g_mid_r
                assign right_elem = cell_elem[gi+1];
            end
            ial_cell #(
                .ELEM_WIDTH (ELEM_WIDTH),
                .IDX_W      (IDX_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_index (IDX_W'(gi)),
                .i_op    (cell_op),
                .i_sel   (cell_sel),
                .i_value (cell_value),
                .i_left  (left_elem),
                .i_right (right_elem),
                .i_head  (cell_elem[0]),
                .o_elem  (cell_elem[gi])
            );
        end
    endgenerate

    ial_ctrl #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH),
        .KEY_WIDTH  (KEY_WIDTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_command        (ial_pkg::t_cmd'(s_axis_tdata[ial_pkg::CMD_W-1:0])),
        .i_position       (s_axis_tdata[IN_VAL-1:IN_POS]),
        .i_elem_value     (s_axis_tdata[IN_KEY-1:IN_VAL]),
        .i_search_key     (s_axis_tdata[IN_KEY+KEY_WIDTH-1:IN_KEY]),
        .i_head           (cell_elem[0]),
        .o_cell_op        (cell_op),
        .o_cell_sel       (cell_sel),
        .o_cell_value     (cell_value),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_status         (out_status),
        .o_elem_out       (out_elem),
        .o_found_position (out_fpos),
        .o_list_length    (out_len)
    );

    assign m_axis_tdata = OUT_W'({out_len, out_fpos, out_elem, out_status});

endmodule
`default_nettype wire

// ===== bench/tb_indexed_array_list_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_array_list_unit
// Self-checking bench for the indexed array list unit. A scoreboard keeps its
// own copy of the list, predicts the result of every accepted command and
// compares each output beat field by field. Directed corner commands come
// first, then random phases that grow, churn and drain the list, with random
// stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb_indexed_array_list_unit;

    localparam int CAP      = ial_pkg::CAPACITY_DEF;
    localparam int EW       = ial_pkg::ELEM_WIDTH_DEF;
    localparam int KW       = ial_pkg::KEY_WIDTH_DEF;
    localparam int CW       = ial_pkg::CMD_W;
    localparam int SW       = ial_pkg::STATUS_W;
    localparam int PW       = $clog2(CAP + 1);
    localparam int IN_W     = ((CW + PW + EW + KW + 7) / 8) * 8;
    localparam int OUT_W    = ((SW + EW + 2 * PW + 7) / 8) * 8;
    localparam int LIMIT    = 1000000;
    localparam int TAIL     = 2 * CAP + 16;

    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIX    = 2;

    typedef struct packed {
        ial_pkg::t_status status;
        logic [EW-1:0]    elem;
        logic [PW-1:0]    found_pos;
        logic [PW-1:0]    length;
    } t_list_result;

    class list_scoreboard;
        logic [EW-1:0] slots [CAP];
        int            fill;
        t_list_result  pending_q [$];
        int            errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction

        function void note_command(ial_pkg::t_cmd cmd, logic [PW-1:0] pos,
                                   logic [EW-1:0] val, logic [KW-1:0] key);
            t_list_result  r;
            logic [EW-1:0] tmp;
            int            p;
            p           = int'(pos);
            r.status    = ial_pkg::ST_OK;
            r.elem      = '0;
            r.found_pos = '0;
            case (cmd)
                ial_pkg::CMD_APPEND: begin
                    if (fill >= CAP) r.status = ial_pkg::ST_FULL;
                    else begin
                        slots[fill] = val;
                        fill++;
                    end
                end
                ial_pkg::CMD_INSERT: begin
                    if (fill >= CAP) r.status = ial_pkg::ST_FULL;
                    else if (p == 0 || p > fill + 1) r.status = ial_pkg::ST_BADPOS;
                    else begin
                        for (int i = fill; i > p - 1; i--) slots[i] = slots[i-1];
                        slots[p-1] = val;
                        fill++;
                    end
                end
                ial_pkg::CMD_DELETE: begin
                    if (fill == 0) r.status = ial_pkg::ST_EMPTY;
                    else if (p == 0 || p > fill) r.status = ial_pkg::ST_BADPOS;
                    else begin
                        for (int i = p - 1; i + 1 < fill; i++) slots[i] = slots[i+1];
                        fill--;
                    end
                end
                ial_pkg::CMD_READ: begin
                    if (fill == 0) r.status = ial_pkg::ST_EMPTY;
                    else if (p == 0 || p > fill) r.status = ial_pkg::ST_BADPOS;
                    else r.elem = slots[p-1];
                end
                ial_pkg::CMD_SEARCH: begin
                    if (fill == 0) r.status = ial_pkg::ST_EMPTY;
                    else begin
                        r.status = ial_pkg::ST_NOTFOUND;
                        for (int i = 0; i < fill; i++) begin
                            if (slots[i][EW-1 -: KW] == key) begin
                                r.status    = ial_pkg::ST_OK;
                                r.elem      = slots[i];
                                r.found_pos = PW'(i + 1);
                                break;
                            end
                        end
                    end
                end
                ial_pkg::CMD_REVERSE: begin
                    if (fill == 0) r.status = ial_pkg::ST_EMPTY;
                    else begin
                        for (int i = 0; i < fill / 2; i++) begin
                            tmp               = slots[i];
                            slots[i]          = slots[fill-1-i];
                            slots[fill-1-i]   = tmp;
                        end
                    end
                end
                ial_pkg::CMD_CLEAR: fill = 0;
                default: ;
            endcase
            r.length = PW'(fill);
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [OUT_W-1:0] beat);
            t_list_result  want;
            logic [SW-1:0] got_status;
            logic [EW-1:0] got_elem;
            logic [PW-1:0] got_pos;
            logic [PW-1:0] got_len;
            got_status = beat[SW-1:0];
            got_elem   = beat[SW +: EW];
            got_pos    = beat[SW + EW +: PW];
            got_len    = beat[SW + EW + PW +: PW];
            if (pending_q.size() == 0) begin
                $error("unexpected result beat: %h", beat);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                errors++;
            end
            if (got_elem !== want.elem) begin
                $error("elem_out: expected %h, got %h", want.elem, got_elem);
                errors++;
            end
            if (got_pos !== want.found_pos) begin
                $error("found_position: expected %0d, got %0d", want.found_pos, got_pos);
                errors++;
            end
            if (got_len !== want.length) begin
                $error("list_length: expected %0d, got %0d", want.length, got_len);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // command, position, elem_value, search_key, zero fill
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // status, elem_out, found_position, list_length, zero fill
    logic [OUT_W-1:0] m_axis_tdata;

    list_scoreboard sb = new();
    bit             rx_idle = 1'b1;
    int             rx_stall_left = 0;
    int             cycles = 0;

    indexed_array_list_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver stalls in bursts of random length, started only while rx_idle is set
    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left--;
        end else if (rx_idle && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left = $urandom_range(0, 15);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    task automatic push_command(input ial_pkg::t_cmd cmd, input logic [PW-1:0] pos,
                                input logic [EW-1:0] val, input logic [KW-1:0] key,
                                input bit may_idle);
        if (may_idle && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tdata  <= {{(IN_W - CW - PW - EW - KW){1'b0}}, key, val, pos, cmd};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(cmd, pos, val, key);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic ial_pkg::t_cmd pick_cmd(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_GROW: begin
                if (r < 40) return ial_pkg::CMD_APPEND;
                if (r < 75) return ial_pkg::CMD_INSERT;
                if (r < 82) return ial_pkg::CMD_DELETE;
                if (r < 88) return ial_pkg::CMD_READ;
                if (r < 94) return ial_pkg::CMD_SEARCH;
                if (r < 97) return ial_pkg::CMD_REVERSE;
                return ial_pkg::CMD_LENGTH;
            end
            MODE_SHRINK: begin
                if (r < 10) return ial_pkg::CMD_APPEND;
                if (r < 20) return ial_pkg::CMD_INSERT;
                if (r < 70) return ial_pkg::CMD_DELETE;
                if (r < 80) return ial_pkg::CMD_READ;
                if (r < 90) return ial_pkg::CMD_SEARCH;
                if (r < 95) return ial_pkg::CMD_REVERSE;
                if (r < 97) return ial_pkg::CMD_LENGTH;
                return ial_pkg::CMD_CLEAR;
            end
            default: begin
                if (r < 18) return ial_pkg::CMD_APPEND;
                if (r < 36) return ial_pkg::CMD_INSERT;
                if (r < 54) return ial_pkg::CMD_DELETE;
                if (r < 68) return ial_pkg::CMD_READ;
                if (r < 84) return ial_pkg::CMD_SEARCH;
                if (r < 92) return ial_pkg::CMD_REVERSE;
                if (r < 97) return ial_pkg::CMD_LENGTH;
                return ial_pkg::CMD_CLEAR;
            end
        endcase
    endfunction

    function automatic logic [PW-1:0] pick_position(input int upper);
        int r;
        r = $urandom_range(0, 9);
        if (r < 8 && upper >= 1) return PW'($urandom_range(1, upper));
        if (r < 9) return ($urandom_range(0, 1) != 0) ? '0 : PW'(upper + 1);
        return PW'($urandom_range(0, 2**PW - 1));
    endfunction

    function automatic logic [KW-1:0] pooled_key();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return KW'(1);
            2: return KW'(2);
            default: return '1;
        endcase
    endfunction

    function automatic logic [EW-1:0] pick_elem();
        if ($urandom_range(0, 1) != 0) return EW'($urandom);
        return {pooled_key(), (EW - KW)'($urandom)};
    endfunction

    function automatic logic [KW-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6 && sb.fill > 0) return sb.slots[$urandom_range(0, sb.fill - 1)][EW-1 -: KW];
        if (r < 8) return pooled_key();
        return KW'($urandom);
    endfunction

    task automatic run_phase(input int count, input int mode, input bit tx_idle_on,
                             input bit rx_idle_on);
        ial_pkg::t_cmd cmd;
        logic [PW-1:0] pos;
        rx_idle = rx_idle_on;
        repeat (count) begin
            cmd = pick_cmd(mode);
            pos = pick_position((cmd == ial_pkg::CMD_INSERT) ? sb.fill + 1 : sb.fill);
            push_command(cmd, pos, pick_elem(), pick_key(), tx_idle_on);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_command(ial_pkg::CMD_LENGTH,  7'd0,   32'h0,        16'h0,    1'b1);
        push_command(ial_pkg::CMD_READ,    7'd1,   32'h0,        16'h0,    1'b1);
        push_command(ial_pkg::CMD_DELETE,  7'd1,   32'h0,        16'h0,    1'b1);
        push_command(ial_pkg::CMD_SEARCH,  7'd0,   32'h0,        16'hFFFF, 1'b1);
        push_command(ial_pkg::CMD_REVERSE, 7'd0,   32'h0,        16'h0,    1'b1);
        push_command(ial_pkg::CMD_INSERT,  7'd2,   32'hDEAD0000, 16'h0,    1'b1);
        push_command(ial_pkg::CMD_INSERT,  7'd0,   32'hDEAD0001, 16'h0,    1'b1);
        push_command(ial_pkg::CMD_INSERT,  7'd1,   32'hFFFFFFFF, 16'h0,    1'b1);
        push_command(ial_pkg::CMD_APPEND,  7'd0,   32'h00000000, 16'h0,    1'b1);
        push_command(ial_pkg::CMD_APPEND,  7'd127, 32'h12345678, 16'hFFFF, 1'b1);
        push_command(ial_pkg::CMD_INSERT,  7'd4,   32'hFFFF0001, 16'h0,    1'b1);
        push_command(ial_pkg::CMD_INSERT,  7'd6,   32'hBEEF0000, 16'h0,    1'b1);
        push_command(ial_pkg::CMD_READ,    7'd0,   32'h0,        16'h0,    1'b1);
        push_command(ial_pkg::CMD_READ,    7'd127, 32'h0,        16'h0,    1'b1);
        push_command(ial_pkg::CMD_READ,    7'd1,   32'h0,        16'h0,    1'b1);
        push_command(ial_pkg::CMD_READ,    7'd4,   32'h0,        16'h0,    1'b1);
        push_command(ial_pkg::CMD_SEARCH,  7'd0,   32'h0,        16'hFFFF, 1'b1);
        push_command(ial_pkg::CMD_SEARCH,  7'd0,   32'h0,        16'h1234, 1'b1);
        push_command(ial_pkg::CMD_SEARCH,  7'd0,   32'h0,        16'hABCD, 1'b1);
        push_command(ial_pkg::CMD_REVERSE, 7'd0,   32'h0,        16'h0,    1'b1);
        push_command(ial_pkg::CMD_READ,    7'd1,   32'h0,        16'h0,    1'b1);
        push_command(ial_pkg::CMD_DELETE,  7'd0,   32'h0,        16'h0,    1'b1);
        push_command(ial_pkg::CMD_DELETE,  7'd4,   32'h0,        16'h0,    1'b1);
        push_command(ial_pkg::CMD_DELETE,  7'd1,   32'h0,        16'h0,    1'b1);
        push_command(ial_pkg::CMD_CLEAR,   7'd0,   32'h0,        16'h0,    1'b1);
        push_command(ial_pkg::CMD_LENGTH,  7'd0,   32'h0,        16'h0,    1'b1);
        drain_results();

        run_phase(250, MODE_GROW,   1'b1, 1'b1);
        drain_results();
        run_phase(300, MODE_MIX,    1'b0, 1'b1);
        run_phase(200, MODE_SHRINK, 1'b1, 1'b0);
        drain_results();
        run_phase(200, MODE_GROW,   1'b0, 1'b0);
        run_phase(150, MODE_MIX,    1'b1, 1'b1);
        run_phase(150, MODE_MIX,    1'b0, 1'b0);

        drain_results();
        repeat (TAIL) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
